/* hw/rtl/lfpi_pkg.sv */
// ----------------------------------------------------------------------------
// lfpi_pkg: shared constants, types and index helpers
// Node and pair numbering, queue sizing and the multiplier slice width used
// by the front, queue and back of the four-point interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpi_pkg;

  // multiplier slice width (slice products formed in parallel)
  localparam int CHUNK_W     = 32;
  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  // stencil
  localparam int NUM_NODES   = 4;
  localparam int NUM_PAIRS   = 6;

  typedef struct packed {
    logic full;
    logic empty;
  } lfpi_q_stat_t;

  // k-th node other than node i, k = 0..2
  function automatic int other_node(int i, int k);
    return (k < i) ? k : k + 1;
  endfunction

  // index of the unordered node pair {a, b}:
  // (0,1)=0 (0,2)=1 (0,3)=2 (1,2)=3 (1,3)=4 (2,3)=5
  function automatic int pair_idx(int a, int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (lo * (7 - lo)) / 2 + (hi - lo - 1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lfpi_if.sv */
// ----------------------------------------------------------------------------
// lfpi_if: item channels of the interpolator
// Valid/ready channels for query items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfpi_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] node_0;
  logic signed [DATA_WIDTH-1:0] node_1;
  logic signed [DATA_WIDTH-1:0] node_2;
  logic signed [DATA_WIDTH-1:0] node_3;
  logic signed [DATA_WIDTH-1:0] sample_0;
  logic signed [DATA_WIDTH-1:0] sample_1;
  logic signed [DATA_WIDTH-1:0] sample_2;
  logic signed [DATA_WIDTH-1:0] sample_3;
  logic signed [DATA_WIDTH-1:0] query_point;

  modport source (
    output valid, node_0, node_1, node_2, node_3,
    output sample_0, sample_1, sample_2, sample_3, query_point,
    input  ready
  );
  modport sink (
    input  valid, node_0, node_1, node_2, node_3,
    input  sample_0, sample_1, sample_2, sample_3, query_point,
    output ready
  );
endinterface

interface lfpi_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] interpolated_value;
  logic                         coincident_nodes;
  logic                         saturated;

  modport source (
    output valid, interpolated_value, coincident_nodes, saturated,
    input  ready
  );
  modport sink (
    input  valid, interpolated_value, coincident_nodes, saturated,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/lfpi_front.sv */
// ----------------------------------------------------------------------------
// lfpi_front: item intake and classification
// Forms distance and sample magnitudes, weighted-sample signs and the
// coincident-node flag per item, and pushes the packed record to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpi_front #(
  parameter int DATA_WIDTH = 32
) (
  lfpi_in_if.sink                          in_ch,
  input  lfpi_pkg::lfpi_q_stat_t           qs,
  output logic                             push,
  output logic [14*DATA_WIDTH+4:0]         wdata
);
  import lfpi_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int OFS_DN = NUM_NODES * W;
  localparam int OFS_YM = OFS_DN + NUM_PAIRS * W;
  localparam int OFS_SG = OFS_YM + NUM_NODES * W;
  localparam int OFS_CO = OFS_SG + NUM_NODES;

  logic signed [W-1:0] x [NUM_NODES];
  logic signed [W-1:0] y [NUM_NODES];
  logic signed [W-1:0] q;

  assign x[0] = in_ch.node_0;
  assign x[1] = in_ch.node_1;
  assign x[2] = in_ch.node_2;
  assign x[3] = in_ch.node_3;
  assign y[0] = in_ch.sample_0;
  assign y[1] = in_ch.sample_1;
  assign y[2] = in_ch.sample_2;
  assign y[3] = in_ch.sample_3;
  assign q    = in_ch.query_point;

  // handshake: take an item whenever the queue has room
  assign in_ch.ready = !qs.full;
  assign push        = in_ch.valid && !qs.full;

  // classification, distance and sample magnitudes
  always_comb begin
    logic signed [W:0] d;
    logic              coinc;
    logic              sg;
    int                jj;
    wdata = '0;
    coinc = 1'b0;
    for (int j = 0; j < NUM_NODES; j++) begin
      d = (W+1)'(q) - (W+1)'(x[j]);
      wdata[j*W +: W] = d[W] ? W'(-d) : d[W-1:0];
    end
    for (int a = 0; a < NUM_NODES; a++) begin
      for (int b = a + 1; b < NUM_NODES; b++) begin
        d = (W+1)'(x[a]) - (W+1)'(x[b]);
        wdata[OFS_DN + pair_idx(a, b)*W +: W] = d[W] ? W'(-d) : d[W-1:0];
        if (x[a] == x[b]) begin
          coinc = 1'b1;
        end
      end
    end
    for (int i = 0; i < NUM_NODES; i++) begin
      d = (W+1)'(y[i]);
      wdata[OFS_YM + i*W +: W] = d[W] ? W'(-d) : d[W-1:0];
      sg = y[i][W-1];
      for (int k = 0; k < NUM_NODES - 1; k++) begin
        jj = other_node(i, k);
        sg = sg ^ (q < x[jj]) ^ (x[i] < x[jj]);
      end
      wdata[OFS_SG + i] = sg;
    end
    wdata[OFS_CO] = coinc;
  end

endmodule

`default_nettype wire

/* hw/rtl/lfpi_queue.sv */
// ----------------------------------------------------------------------------
// lfpi_queue: short queue between front and back
// Register-based FIFO; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpi_queue #(
  parameter int PW = 453
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [PW-1:0]          wdata,
  input  logic                   pop,
  output logic [PW-1:0]          rdata,
  output lfpi_pkg::lfpi_q_stat_t qs
);
  import lfpi_pkg::*;

  logic [PW-1:0]       mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign qs.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qs.empty = (count == '0);
  assign rdata    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qs.full && !pop))
    else $error("queue written while full");

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill level did not follow a push");

endmodule

`default_nettype wire

/* hw/rtl/lfpi_mul.sv */
// ----------------------------------------------------------------------------
// lfpi_mul: two-stage unsigned multiplier
// Operand a is cut into slices; slice products are registered, then summed.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpi_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  import lfpi_pkg::*;

  localparam int NC   = (AW + CHUNK_W - 1) / CHUNK_W;
  localparam int PADW = NC * CHUNK_W;
  localparam int PPW  = CHUNK_W + BW;

  logic [PADW-1:0]    a_pad;
  logic [PPW-1:0]     pp [NC];
  logic [PADW+BW-1:0] sum;

  assign a_pad = PADW'(a);

  // slice products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        pp[c] <= PPW'(a_pad[c*CHUNK_W +: CHUNK_W]) * PPW'(b);
      end
    end
  end

  // weighted sum of slices
  always_comb begin
    sum = '0;
    for (int c = 0; c < NC; c++) begin
      sum = sum + ((PADW+BW)'(pp[c]) << (c * CHUNK_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[AW+BW-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lfpi_div.sv */
// ----------------------------------------------------------------------------
// lfpi_div: pipelined restoring divider
// Unsigned; one quotient bit per stage, NW stages, one division per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpi_div #(
  parameter int NW = 140,
  parameter int DW = 96
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] n_s [NW];
  logic [NW-1:0] q_s [NW];
  logic [DW-1:0] r_s [NW];
  logic [DW-1:0] d_s [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] n_i;
    logic [NW-1:0] q_i;
    logic [DW-1:0] r_i;
    logic [DW-1:0] d_i;
    logic [DW:0]   t;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign n_i = num;
      assign q_i = '0;
      assign r_i = '0;
      assign d_i = den;
    end else begin : g_next
      assign n_i = n_s[k-1];
      assign q_i = q_s[k-1];
      assign r_i = r_s[k-1];
      assign d_i = d_s[k-1];
    end

    // trial subtract of the divisor from the shifted remainder
    assign t    = {r_i, n_i[NW-1]};
    assign diff = t - {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (en) begin
        n_s[k] <= n_i << 1;
        d_s[k] <= d_i;
        if (!diff[DW]) begin
          r_s[k] <= diff[DW-1:0];
          q_s[k] <= {q_i[NW-2:0], 1'b1};
        end else begin
          r_s[k] <= t[DW-1:0];
          q_s[k] <= {q_i[NW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_s[NW-1];

endmodule

`default_nettype wire

/* hw/rtl/lfpi_back.sv */
// ----------------------------------------------------------------------------
// lfpi_back: weight and sum pipeline
// Four lanes form numerator and denominator products and the basis weight,
// scale by the sample, then a shared tail sums, rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpi_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lfpi_pkg::lfpi_q_stat_t   qs,
  input  logic [14*DATA_WIDTH+4:0] qdata,
  output logic                     pop,
  lfpi_out_if.source               out_ch
);
  import lfpi_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int PW     = 14 * W + 5;
  localparam int OFS_DN = NUM_NODES * W;
  localparam int OFS_YM = OFS_DN + NUM_PAIRS * W;
  localparam int OFS_SG = OFS_YM + NUM_NODES * W;
  localparam int OFS_CO = OFS_SG + NUM_NODES;
  localparam int NW     = 3 * W + 2 * FRAC_BITS;   // shifted numerator / weight
  localparam int TW     = NW + W + 3;              // signed term and sum
  localparam int LAT    = NW + 12;
  localparam int DY     = NW + 4;
  localparam int DS     = NW + 6;

  logic             en;
  logic [LAT-1:0]   vld;
  logic [LAT-1:0]   coi;
  logic [PW-1:0]    s0;
  logic signed [TW-1:0] term [NUM_NODES];
  logic signed [TW-1:0] s01;
  logic signed [TW-1:0] s23;
  logic signed [TW-1:0] acc;
  logic             neg_c;
  logic [TW-1:0]    mag_c;
  logic [TW-1:0]    rnd;
  logic [TW-1:0]    m;
  logic [TW-1:0]    lim;
  logic [TW-1:0]    mc;
  logic             over;
  logic [W-1:0]     val;

  // whole pipeline advances unless the result register is held
  assign en           = !vld[LAT-1] || out_ch.ready;
  assign pop          = en && !qs.empty;
  assign out_ch.valid = vld[LAT-1];

  // item tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coi <= {coi[LAT-2:0], qdata[OFS_CO]};
      s0  <= qdata;
    end
  end

  // per-node weight lanes
  for (genvar i = 0; i < NUM_NODES; i++) begin : g_lane
    localparam int J0 = other_node(i, 0);
    localparam int J1 = other_node(i, 1);
    localparam int J2 = other_node(i, 2);
    localparam int P0 = pair_idx(i, J0);
    localparam int P1 = pair_idx(i, J1);
    localparam int P2 = pair_idx(i, J2);

    logic [2*W-1:0]  num1;
    logic [2*W-1:0]  den1;
    logic [3*W-1:0]  num2;
    logic [3*W-1:0]  den2;
    logic [NW-1:0]   wt;
    logic [NW+W-1:0] tmag;
    logic [W-1:0]    qc_d [2];
    logic [W-1:0]    nc_d [2];
    logic [W-1:0]    y_d  [DY];
    logic            sg_d [DS];

    lfpi_mul #(.AW(W), .BW(W)) u_num1 (
      .clk(clk), .en(en), .a(s0[J0*W +: W]), .b(s0[J1*W +: W]), .p(num1)
    );
    lfpi_mul #(.AW(W), .BW(W)) u_den1 (
      .clk(clk), .en(en), .a(s0[OFS_DN + P0*W +: W]), .b(s0[OFS_DN + P1*W +: W]),
      .p(den1)
    );

    // third factors, sample and sign wait for the products and the quotient
    always_ff @(posedge clk) begin
      if (en) begin
        qc_d[0] <= s0[J2*W +: W];
        qc_d[1] <= qc_d[0];
        nc_d[0] <= s0[OFS_DN + P2*W +: W];
        nc_d[1] <= nc_d[0];
        y_d[0]  <= s0[OFS_YM + i*W +: W];
        for (int k = 1; k < DY; k++) begin
          y_d[k] <= y_d[k-1];
        end
        sg_d[0] <= s0[OFS_SG + i];
        for (int k = 1; k < DS; k++) begin
          sg_d[k] <= sg_d[k-1];
        end
      end
    end

    lfpi_mul #(.AW(2*W), .BW(W)) u_num2 (
      .clk(clk), .en(en), .a(num1), .b(qc_d[1]), .p(num2)
    );
    lfpi_mul #(.AW(2*W), .BW(W)) u_den2 (
      .clk(clk), .en(en), .a(den1), .b(nc_d[1]), .p(den2)
    );

    lfpi_div #(.NW(NW), .DW(3*W)) u_div (
      .clk(clk), .en(en), .num({num2, {(2*FRAC_BITS){1'b0}}}), .den(den2), .quo(wt)
    );

    lfpi_mul #(.AW(NW), .BW(W)) u_term (
      .clk(clk), .en(en), .a(wt), .b(y_d[DY-1]), .p(tmag)
    );

    // signed weighted sample
    always_ff @(posedge clk) begin
      if (en) begin
        term[i] <= sg_d[DS-1] ? -(TW'(tmag)) : TW'(tmag);
      end
    end
  end

  // sum, magnitude, then round and clip
  always_comb begin
    rnd  = mag_c + (TW'(1) << (2*FRAC_BITS - 1));
    m    = rnd >> (2*FRAC_BITS);
    lim  = neg_c ? (TW'(1) << (W-1)) : ((TW'(1) << (W-1)) - TW'(1));
    over = (m > lim);
    mc   = over ? lim : m;
    val  = neg_c ? (-mc[W-1:0]) : mc[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s01   <= term[0] + term[1];
      s23   <= term[2] + term[3];
      acc   <= s01 + s23;
      neg_c <= acc[TW-1];
      mag_c <= acc[TW-1] ? TW'(-acc) : TW'(acc);
      out_ch.interpolated_value <= coi[LAT-2] ? '0 : val;
      out_ch.saturated          <= coi[LAT-2] ? 1'b0 : over;
      out_ch.coincident_nodes   <= coi[LAT-2];
    end
  end

  a_coinc_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.coincident_nodes |->
      out_ch.interpolated_value == '0 && !out_ch.saturated)
    else $error("coincident result carries a value");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(vld))
    else $error("pipeline moved while result held");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && !vld[LAT-2] |=> !out_ch.valid)
    else $error("result repeated after hand-off");

endmodule

`default_nettype wire

/* hw/rtl/lagrange_four_point_interpolator.sv */
// ----------------------------------------------------------------------------
// lagrange_four_point_interpolator: four-point cubic Lagrange interpolator
// Signed fixed-point interpolation through four nodes; front classifies,
// queue decouples, back computes weights and the weighted sum.
// ----------------------------------------------------------------------------
//   channel  | dir | payload
//   in_ch    | in  | node_0..3, sample_0..3, query_point
//   out_ch   | out | interpolated_value, coincident_nodes, saturated
//
// One item accepted per cycle while results are taken; one result per item.
// The back pipeline holds the divider, which resolves one quotient bit per stage.
// rst (synchronous) empties the queue and drops items in flight.
// A held result stalls the back pipeline; the queue keeps taking up to four
// items meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module lagrange_four_point_interpolator #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  lfpi_in_if.sink    in_ch,
  lfpi_out_if.source out_ch
);
  import lfpi_pkg::*;

  localparam int PW = 14 * DATA_WIDTH + 5;

  lfpi_q_stat_t  qs;
  logic          push;
  logic          pop;
  logic [PW-1:0] wdata;
  logic [PW-1:0] rdata;

  lfpi_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .in_ch(in_ch), .qs(qs), .push(push), .wdata(wdata)
  );

  lfpi_queue #(.PW(PW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(wdata), .pop(pop),
    .rdata(rdata), .qs(qs)
  );

  lfpi_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .qs(qs), .qdata(rdata), .pop(pop), .out_ch(out_ch)
  );

endmodule

`default_nettype wire

/* tb/lagrange_four_point_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// lagrange_four_point_interpolator_tb: self-checking bench of the interpolator
// Drives query items through the input channel with random gaps, takes the
// results with random back-pressure, and compares each one field by field
// with a wide-arithmetic prediction of the Lagrange sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lagrange_four_point_interpolator_tb;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int WFRAC      = 2 * FRAC_BITS;
  localparam int NUM_RANDOM = 600;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC  = 200;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] node[4];
    logic signed [DATA_WIDTH-1:0] sample[4];
    logic signed [DATA_WIDTH-1:0] query_point;
  } query_t;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] interpolated_value;
    logic                         coincident_nodes;
    logic                         saturated;
  } result_t;

  typedef struct {
    query_t  q;
    bit      has_value;
    result_t value;
  } stim_row_t;

  logic clk;
  logic rst;
  int   errors;
  int   idle_cycles;
  int   stall_left;
  bit   no_idle;

  result_t   pending_results[$];
  stim_row_t stim_table[$];

  lfpi_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
  lfpi_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch ();

  lagrange_four_point_interpolator #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Lagrange sum in 384-bit two's complement, weights truncated toward zero
  function automatic result_t interpolate(query_t qi);
    logic signed [383:0] xs[4];
    logic signed [383:0] ys[4];
    logic signed [383:0] qv;
    logic signed [383:0] num;
    logic signed [383:0] den;
    logic signed [383:0] wt;
    logic signed [383:0] acc;
    logic signed [383:0] mag;
    logic signed [383:0] lim;
    bit                  neg;
    result_t             r;
    r.interpolated_value = '0;
    r.coincident_nodes   = 1'b0;
    r.saturated          = 1'b0;
    for (int i = 0; i < 4; i++) begin
      xs[i] = qi.node[i];
      ys[i] = qi.sample[i];
    end
    qv = qi.query_point;
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        if (qi.node[i] == qi.node[j]) r.coincident_nodes = 1'b1;
    if (r.coincident_nodes) return r;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      num = 384'sd1;
      den = 384'sd1;
      for (int j = 0; j < 4; j++) begin
        if (j != i) begin
          num = num * (qv - xs[j]);
          den = den * (xs[i] - xs[j]);
        end
      end
      wt  = (num <<< WFRAC) / den;
      acc = acc + wt * ys[i];
    end
    // round magnitude half away from zero, then clip
    neg = acc[383];
    mag = neg ? -acc : acc;
    mag = (mag + (384'sd1 <<< (WFRAC - 1))) >>> WFRAC;
    lim = neg ? (384'sd1 <<< (DATA_WIDTH - 1)) : ((384'sd1 <<< (DATA_WIDTH - 1)) - 1);
    if (mag > lim) begin
      mag         = lim;
      r.saturated = 1'b1;
    end
    r.interpolated_value = neg ? -mag[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
    return r;
  endfunction

  function automatic query_t make_query(
    logic signed [31:0] n0, logic signed [31:0] n1,
    logic signed [31:0] n2, logic signed [31:0] n3,
    logic signed [31:0] s0, logic signed [31:0] s1,
    logic signed [31:0] s2, logic signed [31:0] s3,
    logic signed [31:0] qp
  );
    query_t q;
    q.node[0] = n0; q.node[1] = n1; q.node[2] = n2; q.node[3] = n3;
    q.sample[0] = s0; q.sample[1] = s1; q.sample[2] = s2; q.sample[3] = s3;
    q.query_point = qp;
    return q;
  endfunction

  function automatic void add_row(query_t q, bit has_value, result_t value);
    stim_row_t row;
    row.q         = q;
    row.has_value = has_value;
    row.value     = value;
    stim_table.push_back(row);
  endfunction

  function automatic result_t make_result(logic signed [31:0] v, bit coinc, bit sat);
    result_t r;
    r.interpolated_value = v;
    r.coincident_nodes   = coinc;
    r.saturated          = sat;
    return r;
  endfunction

  // random query: mostly tight, distinct stencils; some raw noise and some clashes
  function automatic query_t random_query();
    query_t q;
    int     kind;
    int     a;
    int     b;
    logic signed [31:0] base;
    kind = $urandom_range(0, 99);
    base = $urandom();
    if (kind < 25) begin
      for (int i = 0; i < 4; i++) begin
        q.node[i]   = $urandom();
        q.sample[i] = $urandom();
      end
      q.query_point = $urandom();
    end else begin
      base = $signed($urandom()) >>> $urandom_range(0, 16);
      for (int i = 0; i < 4; i++) begin
        q.node[i]   = base + $signed($urandom_range(0, 32'h0004_0000));
        q.sample[i] = (kind < 60) ? $signed($urandom()) >>> $urandom_range(4, 14)
                                  : $signed($urandom());
      end
      q.query_point = base + $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0001_0000;
    end
    if (kind >= 95) begin
      a = $urandom_range(0, 3);
      b = (a + $urandom_range(1, 3)) % 4;
      q.node[b] = q.node[a];
    end
    return q;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!no_idle) begin
      if (r < 20) n = $urandom_range(1, 3);
      else if (r < 23) n = $urandom_range(15, 60);
    end
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // present one item at a falling edge and hold it until accepted
  task automatic send_query(query_t q, bit has_value, result_t value);
    result_t want;
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.node_0      = q.node[0];
    in_ch.node_1      = q.node[1];
    in_ch.node_2      = q.node[2];
    in_ch.node_3      = q.node[3];
    in_ch.sample_0    = q.sample[0];
    in_ch.sample_1    = q.sample[1];
    in_ch.sample_2    = q.sample[2];
    in_ch.sample_3    = q.sample[3];
    in_ch.query_point = q.query_point;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    want = interpolate(q);
    if (has_value) begin
      if (want.interpolated_value !== value.interpolated_value ||
          want.coincident_nodes !== value.coincident_nodes ||
          want.saturated !== value.saturated)
        report_mismatch("directed row disagrees with prediction");
      want = value;
    end
    pending_results.push_back(want);
    idle_gap();
  endtask

  // result side back-pressure
  initial begin
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !no_idle) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else begin
        int r;
        r = $urandom_range(0, 99);
        out_ch.ready = 1'b1;
        if (r < 18) stall_left = $urandom_range(1, 3);
        else if (r < 21) stall_left = $urandom_range(20, 80);
        else stall_left = 0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (out_ch.interpolated_value !== want.interpolated_value)
          report_mismatch($sformatf("interpolated_value %h, expected %h",
                                    out_ch.interpolated_value, want.interpolated_value));
        if (out_ch.coincident_nodes !== want.coincident_nodes)
          report_mismatch($sformatf("coincident_nodes %b, expected %b",
                                    out_ch.coincident_nodes, want.coincident_nodes));
        if (out_ch.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b, expected %b",
                                    out_ch.saturated, want.saturated));
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lagrange_four_point_interpolator_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    result_t none;
    errors            = 0;
    idle_cycles       = 0;
    no_idle           = 1'b0;
    none              = make_result('0, 1'b0, 1'b0);
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.node_0      = '0;
    in_ch.node_1      = '0;
    in_ch.node_2      = '0;
    in_ch.node_3      = '0;
    in_ch.sample_0    = '0;
    in_ch.sample_1    = '0;
    in_ch.sample_2    = '0;
    in_ch.sample_3    = '0;
    in_ch.query_point = '0;

    // clashing nodes give zero with the flag
    add_row(make_query(0, 0, 0, 0, S_MAX, S_MIN, 1, -1, 0), 1,
            make_result(0, 1'b1, 1'b0));
    add_row(make_query(0, Q_ONE, 2 * Q_ONE, 0, 5, 6, 7, 8, Q_ONE), 1,
            make_result(0, 1'b1, 1'b0));
    add_row(make_query(S_MIN, Q_ONE, S_MIN, S_MAX, 1, 2, 3, 4, S_MAX), 1,
            make_result(0, 1'b1, 1'b0));
    // query on a node returns that node's sample exactly
    for (int i = 0; i < 4; i++) begin
      query_t q;
      q = make_query(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE,
                     7 * Q_ONE, -3 * Q_ONE, S_MAX, S_MIN, i * Q_ONE);
      add_row(q, 1, make_result(q.sample[i], 1'b0, 1'b0));
    end
    // extremes of node span and query, predicted
    add_row(make_query(S_MIN, -1, 1, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN), 0, none);
    add_row(make_query(S_MIN, -1, 1, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0), 0, none);
    // far extrapolation saturates both ways
    add_row(make_query(1, 2, 3, 4, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX), 0, none);
    add_row(make_query(1, 2, 3, 4, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX), 0, none);
    add_row(make_query(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, S_MAX, S_MAX, S_MAX, S_MAX,
                       S_MAX), 0, none);
    // interior points with fractional weights
    add_row(make_query(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 0, Q_ONE, 8 * Q_ONE,
                       27 * Q_ONE, 32'sh0001_8000), 0, none);
    add_row(make_query(-3 * Q_ONE, -Q_ONE, 32'sh0000_4000, 5 * Q_ONE, -Q_ONE, 3, -7,
                       S_MIN, -1), 0, none);
    add_row(make_query(32'sh0000_0001, 32'sh0000_0003, 32'sh0000_0007, 32'sh0000_000f,
                       -1, 1, -1, 1, 32'sh0000_0002), 0, none);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_table[k])
      send_query(stim_table[k].q, stim_table[k].has_value, stim_table[k].value);

    // drain fully once before the random stream
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending_results.size() == 0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      no_idle = (n >= 250 && n < 350);
      send_query(random_query(), 0, none);
    end
    no_idle = 1'b0;
    @(negedge clk);
    in_ch.valid = 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("lagrange_four_point_interpolator_tb passed");
    end else begin
      $display("lagrange_four_point_interpolator_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
